### rtl/itp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

	typedef logic [2:0] op_code_t;
	typedef logic [1:0] weight_t;

	localparam op_code_t CODE_OPEN  = 3'd0;
	localparam op_code_t CODE_PLUS  = 3'd1;
	localparam op_code_t CODE_MINUS = 3'd2;
	localparam op_code_t CODE_MUL   = 3'd3;
	localparam op_code_t CODE_DIV   = 3'd4;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	function automatic logic [7:0] code_char(input op_code_t code);
		logic [7:0] c;
		case (code)
			CODE_OPEN:  c = CH_OPEN;
			CODE_PLUS:  c = CH_PLUS;
			CODE_MINUS: c = CH_MINUS;
			CODE_MUL:   c = CH_MUL;
			CODE_DIV:   c = CH_DIV;
			default:    c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic weight_t code_weight(input op_code_t code);
		weight_t w;
		case (code)
			CODE_PLUS, CODE_MINUS: w = 2'd1;
			CODE_MUL, CODE_DIV:    w = 2'd2;
			default:               w = 2'd0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/itp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface itp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_expression;

	modport source(output valid, output in_char, output end_of_expression, input ready);
	modport sink(input valid, input in_char, input end_of_expression, output ready);
endinterface

`default_nettype wire

### rtl/itp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface itp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       end_of_output;
	logic       stack_overflow;
	logic       unmatched_close;

	modport source(output valid, output out_char, output char_valid, output end_of_output,
		output stack_overflow, output unmatched_close, input ready);
	modport sink(input valid, input out_char, input char_valid, input end_of_output,
		input stack_overflow, input unmatched_close, output ready);
endinterface

`default_nettype wire

### rtl/itp_stack_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module itp_stack_ram #(
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire               clk,
	input  wire               wr_en,
	input  wire [AW-1:0]      wr_addr,
	input  itp_pkg::op_code_t wr_data,
	input  wire               rd_en,
	input  wire [AW-1:0]      rd_addr,
	output itp_pkg::op_code_t rd_data
);

	itp_pkg::op_code_t mem [DEPTH];
	itp_pkg::op_code_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/infix_to_postfix_converter.sv
// A letter or digit goes through S_CHAR into the output register. Items go one at a time
// (ready only in S_IDLE): '(', a space or an ignored byte needs no other state; an operator
// pops, then emits its space in S_SPACE; ')' pops and drops '(' in S_CHK; a flush pops all,
// then S_MARK. Each pop reads the stack RAM in S_RD before S_CHK; emits wait on the output.
// Reset: arst_n clears the sequencer, the stack count, both sticky flags and the output
// valid; the stack RAM is left as is and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 16
) (
	input wire     clk,
	input wire     arst_n,
	itp_in_if.sink   char_in,
	itp_out_if.source char_out
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHAR  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_CHK   = 3'd3;
	localparam logic [2:0] S_POPC  = 3'd4;
	localparam logic [2:0] S_SPACE = 3'd5;
	localparam logic [2:0] S_MARK  = 3'd6;

	localparam logic [1:0] M_OP    = 2'd0;
	localparam logic [1:0] M_CLOSE = 2'd1;
	localparam logic [1:0] M_FLUSH = 2'd2;

	logic [2:0]        state_q, state_d;
	logic [1:0]        mode_q, mode_d;
	logic [CW-1:0]     count_q;
	logic              overflow_q, close_err_q;
	logic              last_q;
	logic [7:0]        ch_q;
	itp_pkg::op_code_t op_q;

	logic              out_valid_q;
	logic [7:0]        out_char_q;
	logic              out_cv_q, out_end_q, out_ovf_q, out_cls_q;

	logic              slot_free;
	logic              accept;
	logic              emit;
	logic [7:0]        emit_char;
	logic              emit_cv, emit_end;
	logic              push_req;
	itp_pkg::op_code_t push_code;
	logic              pop;
	logic              drop_open;
	logic              set_close_err;
	logic              full;
	logic              rd_en;
	itp_pkg::op_code_t top_code;
	itp_pkg::op_code_t stack_rd_data;
	logic              top_pops;

	logic [7:0]        c;
	logic              is_space, is_alnum, is_open, is_close, is_op;
	itp_pkg::op_code_t in_code;

	assign slot_free = !out_valid_q || char_out.ready;
	assign char_in.ready = (state_q == S_IDLE);
	assign accept = char_in.valid && char_in.ready;
	assign full = (count_q >= DEPTH_C);

	// decode the incoming character
	always_comb begin
		c = char_in.in_char;
		is_space = (c == itp_pkg::CH_SPACE);
		is_open  = (c == itp_pkg::CH_OPEN);
		is_close = (c == itp_pkg::CH_CLOSE);
		is_alnum = (c >= itp_pkg::CH_0 && c <= itp_pkg::CH_9) ||
			(c >= itp_pkg::CH_UA && c <= itp_pkg::CH_UZ) ||
			(c >= itp_pkg::CH_LA && c <= itp_pkg::CH_LZ);
		is_op = 1'b1;
		case (c)
			itp_pkg::CH_PLUS:  in_code = itp_pkg::CODE_PLUS;
			itp_pkg::CH_MINUS: in_code = itp_pkg::CODE_MINUS;
			itp_pkg::CH_MUL:   in_code = itp_pkg::CODE_MUL;
			itp_pkg::CH_DIV:   in_code = itp_pkg::CODE_DIV;
			default: begin
				in_code = itp_pkg::CODE_OPEN;
				is_op = 1'b0;
			end
		endcase
	end

	assign top_code = stack_rd_data;

	always_comb begin
		top_pops = (mode_q == M_FLUSH) ||
			((top_code != itp_pkg::CODE_OPEN) &&
			((mode_q == M_CLOSE) ||
			(itp_pkg::code_weight(top_code) >= itp_pkg::code_weight(op_q))));
	end

	always_comb begin
		state_d = state_q;
		mode_d = mode_q;
		emit = 1'b0;
		emit_char = itp_pkg::CH_SPACE;
		emit_cv = 1'b1;
		emit_end = 1'b0;
		push_req = 1'b0;
		push_code = op_q;
		pop = 1'b0;
		drop_open = 1'b0;
		set_close_err = 1'b0;
		rd_en = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_alnum) begin
						state_d = S_CHAR;
					end else if (is_op) begin
						mode_d = M_OP;
						state_d = S_RD;
					end else if (is_close) begin
						mode_d = M_CLOSE;
						state_d = S_RD;
					end else begin
						if (is_open && !is_space) begin
							push_req = 1'b1;
							push_code = itp_pkg::CODE_OPEN;
						end
						if (char_in.end_of_expression) begin
							mode_d = M_FLUSH;
							state_d = S_RD;
						end
					end
				end
			end
			S_CHAR: begin
				if (slot_free) begin
					emit = 1'b1;
					emit_char = ch_q;
					mode_d = M_OP;
					state_d = last_q ? S_RD : S_IDLE;
					if (last_q) begin
						mode_d = M_FLUSH;
					end
				end
			end
			S_RD: begin
				if (count_q != '0) begin
					rd_en = 1'b1;
					state_d = S_CHK;
				end else begin
					case (mode_q)
						M_OP:    state_d = S_SPACE;
						M_FLUSH: state_d = S_MARK;
						default: begin
							set_close_err = 1'b1;
							state_d = last_q ? S_RD : S_IDLE;
							mode_d = M_FLUSH;
						end
					endcase
				end
			end
			S_CHK: begin
				if (top_pops) begin
					if (slot_free) begin
						emit = 1'b1;
						pop = 1'b1;
						state_d = S_POPC;
					end
				end else if (mode_q == M_OP) begin
					state_d = S_SPACE;
				end else begin
					drop_open = 1'b1;
					state_d = last_q ? S_RD : S_IDLE;
					mode_d = M_FLUSH;
				end
			end
			S_POPC: begin
				if (slot_free) begin
					emit = 1'b1;
					emit_char = itp_pkg::code_char(top_code);
					state_d = S_RD;
				end
			end
			S_SPACE: begin
				if (slot_free) begin
					emit = 1'b1;
					push_req = 1'b1;
					state_d = last_q ? S_RD : S_IDLE;
					mode_d = M_FLUSH;
				end
			end
			S_MARK: begin
				if (slot_free) begin
					emit = 1'b1;
					emit_char = itp_pkg::CH_NUL;
					emit_cv = 1'b0;
					emit_end = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	logic [CW-1:0] top_idx;
	assign top_idx = count_q - CW'(1);

	itp_stack_ram #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (push_req && !full),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (push_code),
		.rd_en   (rd_en),
		.rd_addr (top_idx[AW-1:0]),
		.rd_data (stack_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= M_OP;
			count_q <= '0;
			overflow_q <= 1'b0;
			close_err_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q <= mode_d;
			if (accept) begin
				last_q <= char_in.end_of_expression;
			end
			if (push_req && !full) begin
				count_q <= count_q + CW'(1);
			end else if (pop || drop_open) begin
				count_q <= top_idx;
			end
			// the flag lands after the item emitted in the same cycle
			if (push_req && full) begin
				overflow_q <= 1'b1;
			end
			if (set_close_err) begin
				close_err_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= char_in.in_char;
			op_q <= in_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (char_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= emit_char;
			out_cv_q <= emit_cv;
			out_end_q <= emit_end;
			out_ovf_q <= overflow_q;
			out_cls_q <= close_err_q;
		end
	end

	assign char_out.valid = out_valid_q;
	assign char_out.out_char = out_char_q;
	assign char_out.char_valid = out_cv_q;
	assign char_out.end_of_output = out_end_q;
	assign char_out.stack_overflow = out_ovf_q;
	assign char_out.unmatched_close = out_cls_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stack count above depth");

	a_chk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) |-> (count_q != '0))
		else $error("stack decision on an empty stack");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("overflow flag cleared");

	a_cls_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		close_err_q |=> close_err_q)
		else $error("unmatched close flag cleared");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !char_out.ready) |=> $stable(out_char_q))
		else $error("output item overwritten while stalled");

endmodule

`default_nettype wire

### sim/infix_to_postfix_converter_test.sv
`timescale 1ns / 1ps

module infix_to_postfix_converter_test;

	localparam int STACK_DEPTH   = 16;
	localparam int ITEM_TARGET   = 470;
	localparam int CLEAN_TARGET  = 300;
	localparam int TAIL_START    = 410;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 3000;

	typedef struct packed {
		logic [7:0] ch;
		logic       cv;
		logic       eoo;
		logic       ovf;
		logic       unm;
	} postfix_char_t;

	function automatic bit is_alnum(logic [7:0] c);
		return (c >= itp_pkg::CH_0 && c <= itp_pkg::CH_9) ||
			(c >= itp_pkg::CH_UA && c <= itp_pkg::CH_UZ) ||
			(c >= itp_pkg::CH_LA && c <= itp_pkg::CH_LZ);
	endfunction

	function automatic bit acts_on(logic [7:0] c);
		return is_alnum(c) || c == itp_pkg::CH_PLUS || c == itp_pkg::CH_MINUS ||
			c == itp_pkg::CH_MUL || c == itp_pkg::CH_DIV || c == itp_pkg::CH_OPEN ||
			c == itp_pkg::CH_CLOSE;
	endfunction

	class postfix_scoreboard;
		itp_pkg::op_code_t op_stk[STACK_DEPTH];
		int unsigned       depth;
		bit                ovf;
		bit                unm;
		postfix_char_t     expected_postfix[$];
		int                errors;
		int                checked;
		int                markers;
		int unsigned       deepest;

		function int weight_of(itp_pkg::op_code_t c);
			if (c == itp_pkg::CODE_MUL || c == itp_pkg::CODE_DIV)
				return 2;
			if (c == itp_pkg::CODE_PLUS || c == itp_pkg::CODE_MINUS)
				return 1;
			return 0;
		endfunction

		function logic [7:0] char_of(itp_pkg::op_code_t c);
			case (c)
				itp_pkg::CODE_OPEN:  return itp_pkg::CH_OPEN;
				itp_pkg::CODE_PLUS:  return itp_pkg::CH_PLUS;
				itp_pkg::CODE_MINUS: return itp_pkg::CH_MINUS;
				itp_pkg::CODE_MUL:   return itp_pkg::CH_MUL;
				itp_pkg::CODE_DIV:   return itp_pkg::CH_DIV;
				default:             return itp_pkg::CH_NUL;
			endcase
		endfunction

		function void put_char(logic [7:0] ch, logic cv, logic eoo);
			postfix_char_t e;
			e.ch  = ch;
			e.cv  = cv;
			e.eoo = eoo;
			e.ovf = ovf;
			e.unm = unm;
			expected_postfix.insert(expected_postfix.size(), e);
		endfunction

		function void push_code(itp_pkg::op_code_t c);
			if (depth < STACK_DEPTH) begin
				op_stk[depth] = c;
				depth++;
				if (depth > deepest)
					deepest = depth;
			end else begin
				ovf = 1'b1;
			end
		endfunction

		function void pop_emit();
			depth--;
			put_char(itp_pkg::CH_SPACE, 1'b1, 1'b0);
			put_char(char_of(op_stk[depth]), 1'b1, 1'b0);
		endfunction

		// Predict every output character caused by one accepted input item.
		function void predict_postfix(logic [7:0] ch, logic eoe);
			itp_pkg::op_code_t op;
			bit                is_op;
			is_op = 1'b1;
			op = itp_pkg::CODE_OPEN;
			case (ch)
				itp_pkg::CH_PLUS:  op = itp_pkg::CODE_PLUS;
				itp_pkg::CH_MINUS: op = itp_pkg::CODE_MINUS;
				itp_pkg::CH_MUL:   op = itp_pkg::CODE_MUL;
				itp_pkg::CH_DIV:   op = itp_pkg::CODE_DIV;
				default:           is_op = 1'b0;
			endcase
			if (ch == itp_pkg::CH_SPACE) begin
			end else if (is_op) begin
				while (depth > 0 && op_stk[depth - 1] != itp_pkg::CODE_OPEN &&
					weight_of(op_stk[depth - 1]) >= weight_of(op))
					pop_emit();
				// the leading space goes out even when the push is dropped
				put_char(itp_pkg::CH_SPACE, 1'b1, 1'b0);
				push_code(op);
			end else if (is_alnum(ch)) begin
				put_char(ch, 1'b1, 1'b0);
			end else if (ch == itp_pkg::CH_OPEN) begin
				push_code(itp_pkg::CODE_OPEN);
			end else if (ch == itp_pkg::CH_CLOSE) begin
				while (depth > 0 && op_stk[depth - 1] != itp_pkg::CODE_OPEN)
					pop_emit();
				if (depth > 0)
					depth--;
				else
					unm = 1'b1;
			end
			if (eoe) begin
				while (depth > 0)
					pop_emit();
				put_char(itp_pkg::CH_NUL, 1'b0, 1'b1);
			end
		endfunction

		function void check_char(postfix_char_t got);
			postfix_char_t exp;
			if (expected_postfix.size() == 0) begin
				$error("unexpected output item: out_char %h char_valid %b end_of_output %b",
					got.ch, got.cv, got.eoo);
				errors++;
				return;
			end
			exp = expected_postfix.pop_front();
			checked++;
			if (got.eoo)
				markers++;
			if (got.ch !== exp.ch) begin
				$error("out_char: expected %h, got %h", exp.ch, got.ch);
				errors++;
			end
			if (got.cv !== exp.cv) begin
				$error("char_valid: expected %b, got %b", exp.cv, got.cv);
				errors++;
			end
			if (got.eoo !== exp.eoo) begin
				$error("end_of_output: expected %b, got %b", exp.eoo, got.eoo);
				errors++;
			end
			if (got.ovf !== exp.ovf) begin
				$error("stack_overflow: expected %b, got %b", exp.ovf, got.ovf);
				errors++;
			end
			if (got.unm !== exp.unm) begin
				$error("unmatched_close: expected %b, got %b", exp.unm, got.unm);
				errors++;
			end
		endfunction

		function void drain_check();
			if (expected_postfix.size() != 0) begin
				$error("%0d expected output items never arrived", expected_postfix.size());
				errors += expected_postfix.size();
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	itp_in_if  char_in_bus();
	itp_out_if char_out_bus();

	infix_to_postfix_converter #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_in(char_in_bus),
		.char_out(char_out_bus)
	);

	postfix_scoreboard sb = new;

	logic [7:0] expr_q[$];
	bit         idle_on;
	int         fed_items;
	int         exprs;
	int         stall_left;
	int         quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void add_char(logic [7:0] c);
		expr_q.insert(expr_q.size(), c);
	endfunction

	function automatic logic [7:0] pick_alnum();
		int unsigned r;
		r = $urandom_range(0, 61);
		if (r < 10)
			return itp_pkg::CH_0 + 8'(r);
		if (r < 36)
			return itp_pkg::CH_UA + 8'(r - 10);
		return itp_pkg::CH_LA + 8'(r - 36);
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(0, 3))
			0:       return itp_pkg::CH_PLUS;
			1:       return itp_pkg::CH_MINUS;
			2:       return itp_pkg::CH_MUL;
			default: return itp_pkg::CH_DIV;
		endcase
	endfunction

	function automatic logic [7:0] pick_ignored();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (acts_on(c) || c == itp_pkg::CH_SPACE);
		return c;
	endfunction

	function automatic void load_text(string s);
		expr_q.delete();
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endfunction

	// Append a well-formed infix expression with random operands, spacing and stray ignored bytes.
	function automatic void grow_expr(int lvl, int max_lvl);
		int terms;
		terms = $urandom_range(1, 4);
		for (int t = 0; t < terms; t++) begin
			if (t > 0) begin
				if ($urandom_range(0, 4) == 0)
					add_char(itp_pkg::CH_SPACE);
				add_char(pick_op());
			end
			if ($urandom_range(0, 4) == 0)
				add_char(itp_pkg::CH_SPACE);
			if (lvl < max_lvl && $urandom_range(0, 2) == 0) begin
				add_char(itp_pkg::CH_OPEN);
				grow_expr(lvl + 1, max_lvl);
				add_char(itp_pkg::CH_CLOSE);
			end else begin
				repeat ($urandom_range(1, 3))
					add_char(pick_alnum());
			end
			if ($urandom_range(0, 9) == 0)
				add_char(pick_ignored());
		end
	endfunction

	task automatic send_char(logic [7:0] ch, logic eoe);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			char_in_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
		char_in_bus.valid             <= 1'b1;
		char_in_bus.in_char           <= ch;
		char_in_bus.end_of_expression <= eoe;
		do
			@(posedge clk);
		while (!char_in_bus.ready);
		sb.predict_postfix(ch, eoe);
		fed_items++;
	endtask

	task automatic send_expr();
		foreach (expr_q[i])
			send_char(expr_q[i], i == expr_q.size() - 1);
		exprs++;
	endtask

	// Clean expressions keep the stack shallow and never close an empty stack;
	// wild ones nest deep enough to overflow and may carry stray closes.
	task automatic random_expression(bit wild);
		int kind;
		int keep;
		idle_on = (fed_items < TAIL_START) && ($urandom_range(0, 3) != 0);
		kind = $urandom_range(0, 9);
		expr_q.delete();
		if (kind < 9) begin
			grow_expr(0, wild ? 6 : 3);
			if (kind >= 7) begin
				keep = $urandom_range(1, expr_q.size());
				expr_q = expr_q[0:keep - 1];
			end
		end else begin
			repeat ($urandom_range(1, 6))
				add_char(8'($urandom_range(0, 255)));
			if (!wild)
				foreach (expr_q[i])
					if (expr_q[i] == itp_pkg::CH_CLOSE)
						expr_q[i] = itp_pkg::CH_OPEN;
		end
		send_expr();
	endtask

	initial begin
		arst_n = 1'b0;
		char_in_bus.valid = 1'b0;
		char_in_bus.in_char = itp_pkg::CH_NUL;
		char_in_bus.end_of_expression = 1'b0;
		idle_on = 1'b1;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_text("A+b*(c-D)/e");
		send_expr();
		// leftover open parenthesis, skipped space, end on a null byte
		load_text("0 9*( z");
		add_char(itp_pkg::CH_NUL);
		send_expr();
		load_text(".");
		add_char(8'hFF);
		add_char(itp_pkg::CH_MINUS);
		send_expr();
		load_text(" ");
		send_expr();

		while (fed_items < CLEAN_TARGET)
			random_expression(1'b0);

		// overflow, then a close on an empty stack; both flags stay set afterwards
		expr_q.delete();
		repeat (STACK_DEPTH + 2)
			add_char(itp_pkg::CH_OPEN);
		add_char(pick_alnum());
		send_expr();
		load_text(")");
		send_expr();

		while (fed_items < ITEM_TARGET)
			random_expression(1'b1);

		char_in_bus.valid <= 1'b0;
		while (sb.expected_postfix.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		sb.drain_check();
		$display("Fed %0d characters in %0d expressions; checked %0d output items, %0d ends.",
			fed_items, exprs, sb.checked, sb.markers);
		$display("Deepest operator stack %0d of %0d; overflow flag %0b, unmatched-close %0b.",
			sb.deepest, STACK_DEPTH, sb.ovf, sb.unm);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin : out_side
		postfix_char_t got;
		if (!arst_n) begin
			char_out_bus.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (char_out_bus.valid && char_out_bus.ready) begin
				got.ch  = char_out_bus.out_char;
				got.cv  = char_out_bus.char_valid;
				got.eoo = char_out_bus.end_of_output;
				got.ovf = char_out_bus.stack_overflow;
				got.unm = char_out_bus.unmatched_close;
				sb.check_char(got);
			end
			if (stall_left > 0) begin
				char_out_bus.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				char_out_bus.ready <= 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				char_out_bus.ready <= 1'b1;
			end
		end
	end

	// End the run when neither channel moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if ((char_in_bus.valid && char_in_bus.ready) ||
				(char_out_bus.valid && char_out_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule
